// File: rtl/dmx_widget_packet_deframer_macros.svh
// Assertion macros for the widget packet deframer.
`ifndef DMX_WIDGET_PACKET_DEFRAMER_MACROS_SVH
`define DMX_WIDGET_PACKET_DEFRAMER_MACROS_SVH

// Property holds in the same cycle as its trigger.
`define DWPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Property holds in the cycle after its trigger.
`define DWPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dwpd_pkg.sv
// Shared types and constants of the widget packet deframer.
`default_nettype none

package dwpd_pkg;

  localparam logic [7:0] START_CODE = 8'h7E;
  localparam logic [7:0] STOP_BYTE  = 8'hE7;

  localparam logic [7:0] RESET_WANTED_LABEL  = 8'd5;
  localparam logic [9:0] RESET_DELIVER_LIMIT = 10'd513;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_LABEL  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELIVER_LIMIT = 2'd1;

  localparam logic OUT_KIND_PAYLOAD = 1'b0;
  localparam logic OUT_KIND_STATUS  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_BAD_END  = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LABEL,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA,
    PH_END
  } phase_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] payload_byte;
    logic [9:0] byte_index;
    logic       frame_last;
    logic [1:0] frame_status;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/dmx_widget_packet_deframer.sv
// A word accepted into the input register reaches the core, whose result is loaded into the output register.
// Throughput: one word per cycle; a word with a result waits while an untaken
// result holds the output register.
// A result occupies the single output register; a word without result never stalls.
// Reset clears phase to hunting, counters to zero, valid flags and the
// registers to wanted label 5 and delivery limit 513.
`default_nettype none

module dmx_widget_packet_deframer #(
  parameter int MAX_PAYLOAD = 513
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_kind,
  output logic [7:0]                            payload_byte,
  output logic [9:0]                            byte_index,
  output logic                                  frame_last,
  output logic [1:0]                            frame_status,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dwpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [9:0]                       cfg_data
);

  logic              item_valid;
  logic [7:0]        item_byte;
  logic              advance;
  logic              has_res;
  dwpd_pkg::result_t res;
  dwpd_pkg::result_t out_res;
  logic [7:0]        wanted_label;
  logic [9:0]        deliver_limit;

  dwpd_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .wanted_label  (wanted_label),
    .deliver_limit (deliver_limit)
  );

  dwpd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  dwpd_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_byte     (item_byte),
    .advance       (advance),
    .wanted_label  (wanted_label),
    .deliver_limit (deliver_limit),
    .has_res       (has_res),
    .res           (res)
  );

  dwpd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .has_res    (has_res),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign out_kind     = out_res.out_kind;
  assign payload_byte = out_res.payload_byte;
  assign byte_index   = out_res.byte_index;
  assign frame_last   = out_res.frame_last;
  assign frame_status = out_res.frame_status;

endmodule

`default_nettype wire

// File: rtl/dwpd_cfg.sv
// Configuration registers: wanted label and payload delivery limit.
`default_nettype none

module dwpd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dwpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [9:0]                       cfg_data,
  output logic [7:0]                            wanted_label,
  output logic [9:0]                            deliver_limit
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_label  <= dwpd_pkg::RESET_WANTED_LABEL;
      deliver_limit <= dwpd_pkg::RESET_DELIVER_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        dwpd_pkg::CFG_WANTED_LABEL:  wanted_label  <= cfg_data[7:0];
        dwpd_pkg::CFG_DELIVER_LIMIT: deliver_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/dwpd_in_reg.sv
// Input register: holds one received word until the core takes it.
`default_nettype none

module dwpd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       advance,
  output logic            item_valid,
  output logic [7:0]      item_byte
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dwpd_core.sv
// Deframing state machine: phase, remaining length and payload index.
`default_nettype none

`include "dmx_widget_packet_deframer_macros.svh"

module dwpd_core #(
  parameter int MAX_PAYLOAD = 513
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire logic [7:0]        item_byte,
  input  wire logic              advance,
  input  wire logic [7:0]        wanted_label,
  input  wire logic [9:0]        deliver_limit,
  output logic                   has_res,
  output dwpd_pkg::result_t      res
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MAX_LEN16 = 16'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  dwpd_pkg::phase_t phase, phase_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic [9:0]       bytes_seen, bytes_seen_next;
  logic [7:0]       len_lo, len_lo_next;
  logic [15:0]      full_len;

  assign full_len = {item_byte, len_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dwpd_pkg::PH_HUNT;
      remaining  <= '0;
      bytes_seen <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      bytes_seen <= bytes_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      len_lo <= len_lo_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    remaining_next  = remaining;
    bytes_seen_next = bytes_seen;
    len_lo_next     = len_lo;
    has_res         = 1'b0;
    res             = '0;
    case (phase)
      dwpd_pkg::PH_HUNT: begin
        if (item_byte == dwpd_pkg::START_CODE) begin
          phase_next = dwpd_pkg::PH_LABEL;
        end
      end
      dwpd_pkg::PH_LABEL: begin
        if (item_byte == wanted_label) begin
          phase_next = dwpd_pkg::PH_LEN_LO;
        end else if (item_byte == dwpd_pkg::START_CODE) begin
          phase_next = dwpd_pkg::PH_LABEL;
        end else begin
          phase_next = dwpd_pkg::PH_HUNT;
        end
      end
      dwpd_pkg::PH_LEN_LO: begin
        len_lo_next = item_byte;
        phase_next  = dwpd_pkg::PH_LEN_HI;
      end
      dwpd_pkg::PH_LEN_HI: begin
        bytes_seen_next = '0;
        if (full_len > MAX_LEN16) begin
          remaining_next    = '0;
          phase_next        = dwpd_pkg::PH_HUNT;
          has_res           = 1'b1;
          res.out_kind      = dwpd_pkg::OUT_KIND_STATUS;
          res.frame_last    = 1'b1;
          res.frame_status  = dwpd_pkg::ST_TOO_LONG;
        end else begin
          remaining_next = full_len[LEN_W-1:0];
          phase_next = (full_len == 16'd0) ? dwpd_pkg::PH_END : dwpd_pkg::PH_DATA;
        end
      end
      dwpd_pkg::PH_DATA: begin
        remaining_next  = remaining - LEN_W'(1);
        bytes_seen_next = bytes_seen + 10'd1;
        if (remaining == LEN_W'(1)) begin
          phase_next = dwpd_pkg::PH_END;
        end
        if (bytes_seen < deliver_limit) begin
          has_res          = 1'b1;
          res.out_kind     = dwpd_pkg::OUT_KIND_PAYLOAD;
          res.payload_byte = item_byte;
          res.byte_index   = bytes_seen;
        end
      end
      dwpd_pkg::PH_END: begin
        phase_next       = dwpd_pkg::PH_HUNT;
        has_res          = 1'b1;
        res.out_kind     = dwpd_pkg::OUT_KIND_STATUS;
        res.frame_last   = 1'b1;
        res.frame_status = (item_byte == dwpd_pkg::STOP_BYTE) ?
                           dwpd_pkg::ST_OK : dwpd_pkg::ST_BAD_END;
      end
      default: begin
        phase_next = dwpd_pkg::PH_HUNT;
      end
    endcase
  end

  `DWPD_ASSERT_SAME(a_data_len_nonzero, phase == dwpd_pkg::PH_DATA, remaining != '0, "payload phase with zero bytes left")
  `DWPD_ASSERT_SAME(a_len_bounded, 1'b1, remaining <= MAX_LEN, "remaining length above maximum")
  `DWPD_ASSERT_NEXT(a_end_to_hunt, advance && phase == dwpd_pkg::PH_END, phase == dwpd_pkg::PH_HUNT, "end word did not return to hunting")
  `DWPD_ASSERT_NEXT(a_too_long_resync, advance && has_res && phase == dwpd_pkg::PH_LEN_HI, phase == dwpd_pkg::PH_HUNT && remaining == '0, "too-long frame did not resync")
  `DWPD_ASSERT_SAME(a_advance_needs_item, advance, item_valid, "core advanced without a word")

endmodule

`default_nettype wire

// File: rtl/dwpd_out_reg.sv
// Result register: holds one result until taken, and decides when the core advances.
`default_nettype none

module dwpd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire logic              has_res,
  input  wire dwpd_pkg::result_t res,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dwpd_pkg::result_t      out_res
);

  logic load;

  assign advance = item_valid && (!has_res || !out_valid || out_ready);
  assign load    = advance && has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// File: dv/dmx_widget_packet_deframer_checker.sv
// Deframer checker: watches all channels, predicts each result and compares in order.
module dmx_widget_packet_deframer_checker
  import dwpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 513
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic [7:0]             rx_byte,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic                   out_kind,
  input  wire logic [7:0]             payload_byte,
  input  wire logic [9:0]             byte_index,
  input  wire logic                   frame_last,
  input  wire logic [1:0]             frame_status,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [9:0]             cfg_data,
  output int                          fail_count,
  output int                          pending
);

  phase_t      rx_phase;
  logic [15:0] bytes_left;
  logic [9:0]  next_index;
  logic [7:0]  label_reg;
  logic [9:0]  deliver_len;
  result_t     expected_words[$];

  task automatic report_mismatch(input string what, input result_t got, input result_t want);
    $display("mismatch (%s): got kind=%0d byte=%02h idx=%0d last=%0d st=%0d, want kind=%0d byte=%02h idx=%0d last=%0d st=%0d",
             what, got.out_kind, got.payload_byte, got.byte_index, got.frame_last,
             got.frame_status, want.out_kind, want.payload_byte, want.byte_index,
             want.frame_last, want.frame_status);
    fail_count++;
  endtask

  function automatic bit deframe_byte(input logic [7:0] b, output result_t res);
    logic [9:0] idx;
    bit         deliver;
    res = '0;
    deframe_byte = 1'b0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == START_CODE) rx_phase = PH_LABEL;
      end
      PH_LABEL: begin
        if (b == label_reg) rx_phase = PH_LEN_LO;
        else if (b == START_CODE) rx_phase = PH_LABEL;
        else rx_phase = PH_HUNT;
      end
      PH_LEN_LO: begin
        bytes_left = {8'h00, b};
        rx_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        bytes_left = {b, bytes_left[7:0]};
        next_index = '0;
        if (bytes_left > MAX_PAYLOAD) begin
          bytes_left = '0;
          rx_phase = PH_HUNT;
          res.out_kind = OUT_KIND_STATUS;
          res.frame_last = 1'b1;
          res.frame_status = ST_TOO_LONG;
          deframe_byte = 1'b1;
        end else begin
          rx_phase = (bytes_left == 16'd0) ? PH_END : PH_DATA;
        end
      end
      PH_DATA: begin
        idx = next_index;
        deliver = (idx < deliver_len);
        bytes_left = bytes_left - 16'd1;
        next_index = next_index + 10'd1;
        if (bytes_left == 16'd0) rx_phase = PH_END;
        if (deliver) begin
          res.out_kind = OUT_KIND_PAYLOAD;
          res.payload_byte = b;
          res.byte_index = idx;
          deframe_byte = 1'b1;
        end
      end
      PH_END: begin
        rx_phase = PH_HUNT;
        res.out_kind = OUT_KIND_STATUS;
        res.frame_last = 1'b1;
        res.frame_status = (b == STOP_BYTE) ? ST_OK : ST_BAD_END;
        deframe_byte = 1'b1;
      end
      default: rx_phase = PH_HUNT;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      rx_phase = PH_HUNT;
      bytes_left = '0;
      next_index = '0;
      label_reg = RESET_WANTED_LABEL;
      deliver_len = RESET_DELIVER_LIMIT;
      expected_words.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_kind, payload_byte, byte_index, frame_last, frame_status};
        if (expected_words.size() == 0) begin
          report_mismatch("no word expected", got, '0);
        end else begin
          want = expected_words.pop_front();
          if (got.out_kind !== want.out_kind || got.payload_byte !== want.payload_byte ||
              got.byte_index !== want.byte_index || got.frame_last !== want.frame_last ||
              got.frame_status !== want.frame_status) begin
            report_mismatch("field", got, want);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (deframe_byte(rx_byte, want)) expected_words.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WANTED_LABEL: label_reg = cfg_data[7:0];
          CFG_DELIVER_LIMIT: deliver_len = cfg_data;
          default: ;
        endcase
      end
      pending <= expected_words.size();
    end
  end

endmodule

// File: dv/dmx_widget_packet_deframer_test.sv
// Deframer testbench top: clock, reset, byte and register stimulus, and the verdict.
module dmx_widget_packet_deframer_test;
  import dwpd_pkg::*;

  localparam int MAX_PAYLOAD = 513;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             rx_byte = 8'h00;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_kind;
  logic [7:0]             payload_byte;
  logic [9:0]             byte_index;
  logic                   frame_last;
  logic [1:0]             frame_status;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_WANTED_LABEL;
  logic [9:0]             cfg_data = 10'd0;
  int                     fail_count;
  int                     pending;

  int         idle_pct = 13;
  int         big_left = 3;
  logic [7:0] cur_label = RESET_WANTED_LABEL;

  logic [7:0] opening [26] = '{
    8'hFF,
    START_CODE, START_CODE, RESET_WANTED_LABEL, 8'h02, 8'h00, 8'h00, 8'hFF, STOP_BYTE,
    START_CODE, 8'h06,
    START_CODE, RESET_WANTED_LABEL, 8'h00, 8'h00, START_CODE,
    START_CODE, RESET_WANTED_LABEL, 8'h02, 8'h02,
    START_CODE, RESET_WANTED_LABEL, 8'h01, 8'h00, 8'hAA, STOP_BYTE
  };

  dmx_widget_packet_deframer #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .payload_byte(payload_byte), .byte_index(byte_index), .frame_last(frame_last),
    .frame_status(frame_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dmx_widget_packet_deframer_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) deframe_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .payload_byte(payload_byte), .byte_index(byte_index), .frame_last(frame_last),
    .frame_status(frame_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [9:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_frame(input logic [7:0] lbl, input logic [15:0] len, input int body,
                            input logic [7:0] tail);
    send_word(START_CODE);
    send_word(lbl);
    send_word(len[7:0]);
    send_word(len[15:8]);
    repeat (body) send_word(8'($urandom));
    send_word(tail);
  endtask

  function automatic logic [7:0] bad_tail();
    logic [7:0] b;
    if ($urandom_range(2) == 0) return START_CODE;
    do b = 8'($urandom); while (b == STOP_BYTE);
    return b;
  endfunction

  task automatic random_traffic(input int words);
    int          stop;
    int          pick;
    int          body;
    logic [15:0] len;
    logic [7:0]  lbl;
    stop = 0;
    while (stop < words) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        if (big_left > 0 && $urandom_range(99) < 2) begin
          len = 16'($urandom_range(480, 513));
          big_left--;
        end else begin
          len = 16'($urandom_range(24));
        end
        send_frame(cur_label, len, len, ($urandom_range(9) == 0) ? bad_tail() : STOP_BYTE);
        stop += len + 5;
      end else if (pick < 68) begin
        len = 16'($urandom_range(4, 24));
        body = $urandom_range(len - 1);
        send_frame(cur_label, len, body, 8'($urandom));
        stop += body + 5;
      end else if (pick < 76) begin
        case ($urandom_range(2))
          0: len = 16'd514;
          1: len = 16'hFFFF;
          default: len = 16'($urandom_range(514, 65535));
        endcase
        send_frame(cur_label, len, 0, 8'($urandom));
        stop += 5;
      end else if (pick < 84) begin
        do lbl = 8'($urandom); while (lbl == cur_label);
        send_word(START_CODE);
        send_word(lbl);
        stop += 2;
      end else if (pick < 90) begin
        send_word(START_CODE);
        len = 16'($urandom_range(8));
        send_frame(cur_label, len, len, STOP_BYTE);
        stop += len + 6;
      end else begin
        body = $urandom_range(1, 6);
        repeat (body) send_word(8'($urandom));
        stop += body;
      end
      if ($urandom_range(149) == 0) wait_until_drained();
    end
  endtask

  task automatic run_phase(input logic [7:0] lbl, input logic [9:0] len, input int words);
    wait_until_drained();
    write_reg(CFG_WANTED_LABEL, {2'($urandom_range(3)), lbl});
    write_reg(CFG_DELIVER_LIMIT, len);
    write_reg(CFG_UNUSED, 10'($urandom));
    cfg_valid <= 1'b0;
    cur_label = lbl;
    random_traffic(words);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (opening[i]) send_word(opening[i]);

    run_phase(8'h00, 10'd513, 160);
    send_frame(cur_label, 16'd513, 513, STOP_BYTE);
    run_phase(8'hFF, 10'd0, 160);
    run_phase(START_CODE, 10'd3, 160);
    idle_pct = 0;
    run_phase(8'($urandom), 10'd1023, 160);
    idle_pct = 13;
    run_phase(8'($urandom), 10'($urandom_range(513)), 160);
    run_phase(RESET_WANTED_LABEL, 10'd1, 160);

    wait_until_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
